// ===== rtl/core/gbci_pkg.sv =====
// shared widths, register indexes and the burst record of the gyro integrator
`default_nettype none

package gbci_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned BIAS_W   = 36;
  localparam int unsigned DELTA_W  = 38;
  localparam int unsigned ANGLE_W  = 48;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DIFF_W   = BIAS_W + 1;
  localparam int unsigned PROD_W   = DIFF_W + ALPHA_W + 1;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CfgCalibBursts = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CfgEmaAlpha    = 8'd1;

  localparam logic [CNT_W-1:0]   CalibBurstsReset = 16'd999;
  localparam logic [ALPHA_W-1:0] EmaAlphaReset    = 16'd3277;

  // one finished burst leaving the accumulator
  typedef struct packed {
    logic                    integ;
    logic signed [SUM_W-1:0] sum;
  } burst_t;

endpackage

`default_nettype wire

// ===== rtl/core/gyro_bias_cal_trapezoid_integrator.sv =====
// Gyro Z-rate integrator: one 16-bit sample (two bytes) is accepted per clock
// cycle unless the input stalls. Every SAMPLES_PER_BURST samples close a burst
// whose result passes through the s1, s2, s3 and result registers. The first
// calib_bursts bursts refine a Q16 bias estimate (exponential average with
// weight ema_alpha); later bursts integrate the bias-corrected burst sum into a
// saturating Q16 angle by the trapezoid rule. The bias update (subtract,
// multiply, add) runs through three registered stages, and the next burst may
// enter them only once the previous one has reached the last stage; so with
// SAMPLES_PER_BURST of 3 or more the input never stalls except under output
// back-pressure, and with 1 or 2 the last sample of a burst stalls until then.
// While a result waits the pipeline holds; samples are still taken up to the
// last of a burst, which stalls. Configuration is written through a write
// port that is always ready; indexes other than 0 and 1 are ignored.
`default_nettype none

module gyro_bias_cal_trapezoid_integrator #(
  parameter int unsigned SAMPLES_PER_BURST = 16
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire  [7:0]                              sample_high_byte_i,
  input  wire  [7:0]                              sample_low_byte_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic                                    integrating_o,
  output logic signed [gbci_pkg::SUM_W-1:0]       burst_total_o,
  output logic signed [gbci_pkg::BIAS_W-1:0]      bias_estimate_o,
  output logic signed [gbci_pkg::DELTA_W-1:0]     rate_delta_o,
  output logic signed [gbci_pkg::ANGLE_W-1:0]     angle_total_o,
  input  wire                                     cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire  [gbci_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire  [gbci_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned SumW   = gbci_pkg::SUM_W;
  localparam int unsigned BiasW  = gbci_pkg::BIAS_W;
  localparam int unsigned DeltaW = gbci_pkg::DELTA_W;
  localparam int unsigned AngleW = gbci_pkg::ANGLE_W;
  localparam int unsigned DiffW  = gbci_pkg::DIFF_W;
  localparam int unsigned ProdW  = gbci_pkg::PROD_W;
  localparam int unsigned FracW  = gbci_pkg::FRAC_W;

  // configuration
  logic [gbci_pkg::CNT_W-1:0]   calib_q;
  logic [gbci_pkg::ALPHA_W-1:0] alpha_q;

  // accumulator side
  logic             burst_valid;
  gbci_pkg::burst_t burst;
  logic             slot_free;
  logic             adv;

  // stage valids
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;

  // stage payloads
  gbci_pkg::burst_t         s1_q;
  logic                     s2_integ_q, s3_integ_q, out_integ_q;
  logic signed [SumW-1:0]   s2_sum_q, s3_sum_q, out_sum_q;
  logic signed [DiffW-1:0]  s2_diff_q;
  logic signed [DeltaW-1:0] s3_delta_q, s3_step_q, out_delta_q;

  // running state
  logic signed [BiasW-1:0]  bias_q;
  logic signed [DeltaW-1:0] last_delta_q;
  logic signed [AngleW-1:0] angle_q;

  // datapath
  logic signed [BiasW-1:0]  sum_q16;
  logic signed [DiffW-1:0]  diff;
  logic signed [DeltaW-1:0] delta_ext;
  logic signed [ProdW-1:0]  prod;
  logic signed [DeltaW:0]   half_sum;
  logic signed [DeltaW-1:0] step;
  logic signed [DeltaW:0]   bias_sum;
  logic signed [BiasW-1:0]  bias_nxt;
  logic signed [AngleW:0]   angle_sum;
  logic signed [AngleW-1:0] angle_nxt;

  gbci_accum #(
    .SAMPLES_PER_BURST(SAMPLES_PER_BURST)
  ) u_accum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .sample_high_byte_i(sample_high_byte_i),
    .sample_low_byte_i (sample_low_byte_i),
    .in_stall_o        (in_stall_o),
    .slot_free_i       (slot_free),
    .calib_bursts_i    (calib_q),
    .burst_valid_o     (burst_valid),
    .burst_o           (burst)
  );

  assign adv = !out_v_q || !out_stall_i;
  // a new burst enters only after the previous one reaches the bias update stage
  assign slot_free = adv && !s1_v_q && !s2_v_q;

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= gbci_pkg::CalibBurstsReset;
      alpha_q <= gbci_pkg::EmaAlphaReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gbci_pkg::CfgCalibBursts: calib_q <= cfg_data_i;
        gbci_pkg::CfgEmaAlpha:    alpha_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 2: burst sum in q16 minus bias
  assign sum_q16 = {s1_q.sum, {FracW{1'b0}}};
  assign diff    = {sum_q16[BiasW-1], sum_q16} - {bias_q[BiasW-1], bias_q};

  // stage 3: bias step or trapezoid half-sum
  assign delta_ext = {{(DeltaW - DiffW){s2_diff_q[DiffW-1]}}, s2_diff_q};
  assign prod      = s2_diff_q * $signed({1'b0, alpha_q});
  assign half_sum  = {delta_ext[DeltaW-1], delta_ext} + {last_delta_q[DeltaW-1], last_delta_q};
  assign step      = s2_integ_q ? half_sum[DeltaW:1] : prod[FracW+DeltaW-1:FracW];

  // result stage: saturating bias and angle updates
  assign bias_sum  = {{(DeltaW + 1 - BiasW){bias_q[BiasW-1]}}, bias_q}
                   + {s3_step_q[DeltaW-1], s3_step_q};
  assign angle_sum = {{(AngleW + 1 - BiasW){1'b0}}, {BiasW{1'b0}}}
                   + {{(AngleW + 1 - AngleW){angle_q[AngleW-1]}}, angle_q}
                   + {{(AngleW + 1 - DeltaW){s3_step_q[DeltaW-1]}}, s3_step_q};

  always_comb begin
    if ((bias_sum[DeltaW:BiasW-1] == '0) || (bias_sum[DeltaW:BiasW-1] == '1)) begin
      bias_nxt = bias_sum[BiasW-1:0];
    end else begin
      bias_nxt = bias_sum[DeltaW] ? {1'b1, {(BiasW-1){1'b0}}} : {1'b0, {(BiasW-1){1'b1}}};
    end
  end

  always_comb begin
    if (angle_sum[AngleW] != angle_sum[AngleW-1]) begin
      angle_nxt = angle_sum[AngleW] ? {1'b1, {(AngleW-1){1'b0}}}
                                    : {1'b0, {(AngleW-1){1'b1}}};
    end else begin
      angle_nxt = angle_sum[AngleW-1:0];
    end
  end

  // control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      bias_q       <= '0;
      last_delta_q <= '0;
      angle_q      <= '0;
    end else if (adv) begin
      s1_v_q  <= burst_valid;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
      if (s2_v_q && s2_integ_q) begin
        last_delta_q <= delta_ext;
      end
      if (s3_v_q) begin
        if (s3_integ_q) begin
          angle_q <= angle_nxt;
        end else begin
          bias_q <= bias_nxt;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q        <= burst;
      s2_integ_q  <= s1_q.integ;
      s2_sum_q    <= s1_q.sum;
      s2_diff_q   <= diff;
      s3_integ_q  <= s2_integ_q;
      s3_sum_q    <= s2_sum_q;
      s3_delta_q  <= delta_ext;
      s3_step_q   <= step;
      out_integ_q <= s3_integ_q;
      out_sum_q   <= s3_sum_q;
      out_delta_q <= s3_integ_q ? s3_delta_q : '0;
    end
  end

  assign out_valid_o     = out_v_q;
  assign integrating_o   = out_integ_q;
  assign burst_total_o   = out_sum_q;
  assign bias_estimate_o = bias_q;
  assign rate_delta_o    = out_delta_q;
  assign angle_total_o   = angle_q;

`ifndef SYNTHESIS
  // only one burst at a time ahead of the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({s1_v_q, s2_v_q, s3_v_q}) <= 1)
    else $error("more than one burst in flight");

  // bias moves only when a calibrating burst completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && s3_v_q && !s3_integ_q) |=> $stable(bias_q))
    else $error("bias changed outside a calibration update");

  // angle moves only when an integrating burst completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && s3_v_q && s3_integ_q) |=> $stable(angle_q))
    else $error("angle changed outside an integration update");

  // a calibrating result carries no rate delta
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !integrating_o) |-> (rate_delta_o == '0))
    else $error("nonzero delta while calibrating");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/gbci_accum.sv =====
// sample accumulator: byte pairs to a saturating burst sum and burst counter
`default_nettype none

module gbci_accum #(
  parameter int unsigned SAMPLES_PER_BURST = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  input  wire  [7:0]                           sample_high_byte_i,
  input  wire  [7:0]                           sample_low_byte_i,
  output logic                                 in_stall_o,
  input  wire                                  slot_free_i,
  input  wire  [gbci_pkg::CNT_W-1:0]           calib_bursts_i,
  output logic                                 burst_valid_o,
  output gbci_pkg::burst_t                     burst_o
);

  localparam int unsigned IdxW = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SAMPLES_PER_BURST - 1);
  localparam int unsigned SumW = gbci_pkg::SUM_W;
  localparam int unsigned CntW = gbci_pkg::CNT_W;

  logic [IdxW-1:0]        idx_q, idx_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        seen_q, seen_d;

  logic                   is_last;
  logic                   accept;
  logic signed [gbci_pkg::SAMPLE_W-1:0] sample;
  logic signed [SumW:0]   tot;
  logic signed [SumW-1:0] sum_sat;
  logic [CntW-1:0]        seen_inc;

  assign is_last    = (idx_q == LastIdx);
  // the last sample of a burst waits for a free slot in the burst pipeline
  assign in_stall_o = is_last && !slot_free_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign sample = $signed({sample_high_byte_i, sample_low_byte_i});
  assign tot    = {sum_q[SumW-1], sum_q}
                + {{(SumW + 1 - gbci_pkg::SAMPLE_W){sample[gbci_pkg::SAMPLE_W-1]}}, sample};

  always_comb begin
    if (tot[SumW] != tot[SumW-1]) begin
      sum_sat = tot[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = tot[SumW-1:0];
    end
  end

  assign seen_inc = (seen_q == {CntW{1'b1}}) ? seen_q : seen_q + CntW'(1);

  always_comb begin
    idx_d  = idx_q;
    sum_d  = sum_q;
    seen_d = seen_q;
    if (accept) begin
      if (is_last) begin
        idx_d  = '0;
        sum_d  = '0;
        seen_d = seen_inc;
      end else begin
        idx_d  = idx_q + IdxW'(1);
        sum_d  = sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      sum_q  <= '0;
      seen_q <= '0;
    end else begin
      idx_q  <= idx_d;
      sum_q  <= sum_d;
      seen_q <= seen_d;
    end
  end

  assign burst_valid_o = accept && is_last;
  assign burst_o.sum   = sum_sat;
  assign burst_o.integ = (seen_inc > calib_bursts_i);

endmodule

`default_nettype wire
